@@ sv/wwme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wwme_pkg;

	localparam int MAX_WORDS   = 1024;
	localparam int MAX_LETTERS = 12;
	localparam int LETTER_W    = 5;
	localparam int ID_W        = 10;
	localparam int CNT_W       = 11;
	localparam int LEN_W       = 4;
	localparam int LETTERS_W   = 60;
	localparam int MASK_W      = 26;
	localparam int WORD_W      = LEN_W + ID_W + LETTERS_W;
	localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
	localparam logic [MASK_W-1:0] ALL_LETTERS_MASK = 26'h3FFFFFF;
	localparam logic [LEN_W-1:0] MIN_LEN_RESET = 4'd2;

	localparam logic [2:0] FUNC_INSERT  = 3'd0;
	localparam logic [2:0] FUNC_EXCLUDE = 3'd1;
	localparam logic [2:0] FUNC_CLEAR   = 3'd2;
	localparam logic [2:0] FUNC_NEXT    = 3'd3;
	localparam logic [2:0] FUNC_LMASK   = 3'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_BAD      = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} state_t;

	// One dictionary entry travelling down the cell row.
	typedef struct packed {
		logic                 ok;
		logic                 last;
		logic [ID_W-1:0]      rank;
		logic [LETTERS_W-1:0] letters;
	} cell_bus_t;

endpackage
`default_nettype wire

@@ sv/wwme_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wwme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ sv/wwme_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wwme_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [wwme_pkg::LETTER_W-1:0]  pat_letter,
	input  wire logic                           care,
	input  wire wwme_pkg::cell_bus_t            bus_in,
	output wwme_pkg::cell_bus_t                 bus_out
);
	wwme_pkg::cell_bus_t bus_q;
	logic                hit;

	// Each cell checks the lowest letter, then rotates the word so the next
	// cell sees the following position.
	assign hit = !care || (bus_in.letters[wwme_pkg::LETTER_W-1:0] == pat_letter);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= '0;
		end else begin
			bus_q.ok      <= bus_in.ok && hit;
			bus_q.last    <= bus_in.last;
			bus_q.rank    <= bus_in.rank;
			bus_q.letters <= {bus_in.letters[wwme_pkg::LETTER_W-1:0],
				bus_in.letters[wwme_pkg::LETTERS_W-1:wwme_pkg::LETTER_W]};
		end
	end

	assign bus_out = bus_q;
endmodule
`default_nettype wire

@@ sv/wildcard_word_match_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Command-style dictionary matcher. Insert, exclude and unused codes answer
// on the cycle after start is taken, as do next match and letter mask when
// the query is bad or no word is stored. Otherwise those two scan every
// stored word once, one word per cycle, through a row of twelve letter-compare
// cells behind two memory reads. Clear exclusions sweeps the exclusion
// memory, and the same sweep runs after reset, during which busy is high.
// Each result appears for one cycle with done high and must be taken then;
// busy low means a new command can be started. The configuration register
// may be written at any time the block is not busy.
module wildcard_word_match_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  func,
	input  wire logic [59:0] letters,
	input  wire logic [11:0] wild_mask,
	input  wire logic [3:0]  word_len,
	input  wire logic [9:0]  id_operand,
	input  wire logic [3:0]  letter_pos,
	output logic             done,
	output logic [1:0]       status,
	output logic [9:0]       result_id,
	output logic [25:0]      letter_mask,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_wdata
);
	localparam int NL = wwme_pkg::MAX_LETTERS;
	localparam int LW = wwme_pkg::LETTER_W;

	wwme_pkg::state_t state_q, state_d;

	logic [wwme_pkg::LEN_W-1:0] min_len_q;
	logic [wwme_pkg::CNT_W-1:0] count_q;
	logic [wwme_pkg::CNT_W-1:0] len_count_q [NL+1];
	logic [wwme_pkg::ID_W-1:0]  clr_q;
	logic                       clr_report_q;
	logic [wwme_pkg::ID_W-1:0]  scan_q;
	logic [wwme_pkg::ID_W-1:0]  last_addr_q;

	logic [wwme_pkg::LETTERS_W-1:0] pat_q;
	logic [NL-1:0]                  care_q;
	logic                           all_wild_q;
	logic [wwme_pkg::LEN_W-1:0]     len_q;
	logic [wwme_pkg::ID_W-1:0]      idop_q;
	logic [wwme_pkg::LEN_W-1:0]     pos_q;
	logic [2:0]                     func_q;
	logic                           found_q;
	logic [wwme_pkg::ID_W-1:0]      hit_id_q;
	logic [wwme_pkg::MASK_W-1:0]    hit_mask_q;

	logic                        done_q;
	logic [1:0]                  status_q;
	logic [wwme_pkg::ID_W-1:0]   rid_q;
	logic [wwme_pkg::MASK_W-1:0] lmask_q;

	logic v_s1, last_s1, v_s2, last_s2;
	logic [wwme_pkg::WORD_W-1:0] word_rdata, word_s2;
	logic                        excl_rdata;

	logic                        accept, len_ok, bad_letter, pos_bad, query_ok;
	logic [wwme_pkg::LETTERS_W-1:0] len_letters;
	logic [NL-1:0]               care_d;
	logic                        issue;
	logic                        excl_we, excl_wdata;
	logic [wwme_pkg::ID_W-1:0]   excl_waddr;
	logic                        word_we;
	logic [wwme_pkg::WORD_W-1:0] word_wdata;

	wwme_pkg::cell_bus_t chain [NL+1];
	logic [LW-1:0]               code;
	logic                        found_d;
	logic [wwme_pkg::ID_W-1:0]   hit_id_d;
	logic [wwme_pkg::MASK_W-1:0] hit_mask_d;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		len_ok = (word_len != '0) && (word_len >= min_len_q)
			&& (word_len <= wwme_pkg::LEN_W'(NL));
		bad_letter  = 1'b0;
		len_letters = '0;
		care_d      = '0;
		for (int p = 0; p < NL; p++) begin
			if (wwme_pkg::LEN_W'(p) < word_len) begin
				len_letters[p*LW +: LW] = letters[p*LW +: LW];
				care_d[p] = !wild_mask[p];
				if (letters[p*LW +: LW] > wwme_pkg::LAST_LETTER) begin
					bad_letter = 1'b1;
				end
			end
		end
		pos_bad  = (func == wwme_pkg::FUNC_LMASK) && (letter_pos >= word_len);
		query_ok = len_ok && !pos_bad;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wwme_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == wwme_pkg::FUNC_CLEAR) begin
						state_d = wwme_pkg::ST_CLEAR;
					end else if ((func == wwme_pkg::FUNC_NEXT || func == wwme_pkg::FUNC_LMASK)
						&& query_ok && count_q != '0) begin
						state_d = wwme_pkg::ST_SCAN;
					end
				end
			end
			wwme_pkg::ST_SCAN: begin
				if (scan_q == last_addr_q) begin
					state_d = wwme_pkg::ST_WAIT;
				end
			end
			wwme_pkg::ST_WAIT: begin
				if (chain[NL].last) begin
					state_d = wwme_pkg::ST_IDLE;
				end
			end
			wwme_pkg::ST_CLEAR: begin
				if (clr_q == wwme_pkg::ID_W'(wwme_pkg::MAX_WORDS - 1)) begin
					state_d = wwme_pkg::ST_IDLE;
				end
			end
			default: state_d = wwme_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		busy       = (state_q != wwme_pkg::ST_IDLE);
		issue      = (state_q == wwme_pkg::ST_SCAN);
		excl_we    = 1'b0;
		excl_waddr = id_operand;
		excl_wdata = 1'b1;
		if (state_q == wwme_pkg::ST_CLEAR) begin
			excl_we    = 1'b1;
			excl_waddr = clr_q;
			excl_wdata = 1'b0;
		end else if (accept && func == wwme_pkg::FUNC_EXCLUDE
			&& {1'b0, id_operand} < wwme_pkg::CNT_W'(wwme_pkg::MAX_WORDS)) begin
			excl_we = 1'b1;
		end
	end

	assign word_we = accept && func == wwme_pkg::FUNC_INSERT && len_ok && !bad_letter
		&& count_q < wwme_pkg::CNT_W'(wwme_pkg::MAX_WORDS);
	assign word_wdata = {word_len, len_count_q[word_len][wwme_pkg::ID_W-1:0], len_letters};

	wwme_ram #(.WIDTH(wwme_pkg::WORD_W), .DEPTH(wwme_pkg::MAX_WORDS)) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (count_q[wwme_pkg::ID_W-1:0]),
		.wdata (word_wdata),
		.raddr (scan_q),
		.rdata (word_rdata)
	);

	wwme_ram #(.WIDTH(1), .DEPTH(wwme_pkg::MAX_WORDS)) u_excl_ram (
		.clk   (clk),
		.we    (excl_we),
		.waddr (excl_waddr),
		.wdata (excl_wdata),
		.raddr (word_rdata[wwme_pkg::LETTERS_W +: wwme_pkg::ID_W]),
		.rdata (excl_rdata)
	);

	always_comb begin
		chain[0].ok = v_s2
			&& (word_s2[wwme_pkg::LETTERS_W + wwme_pkg::ID_W +: wwme_pkg::LEN_W] == len_q)
			&& (all_wild_q || !excl_rdata);
		chain[0].last    = v_s2 && last_s2;
		chain[0].rank    = word_s2[wwme_pkg::LETTERS_W +: wwme_pkg::ID_W];
		chain[0].letters = word_s2[wwme_pkg::LETTERS_W-1:0];
	end

	for (genvar g = 0; g < NL; g++) begin : g_cell
		wwme_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.pat_letter (pat_q[g*LW +: LW]),
			.care       (care_q[g]),
			.bus_in     (chain[g]),
			.bus_out    (chain[g+1])
		);
	end

	// Combine the entry leaving the last cell with what was found so far.
	always_comb begin
		code = '0;
		for (int p = 0; p < NL; p++) begin
			if (pos_q == wwme_pkg::LEN_W'(p)) begin
				code = chain[NL].letters[p*LW +: LW];
			end
		end
		found_d    = found_q;
		hit_id_d   = hit_id_q;
		hit_mask_d = hit_mask_q;
		if (chain[NL].ok) begin
			if (func_q == wwme_pkg::FUNC_NEXT) begin
				if (!found_q && chain[NL].rank >= idop_q) begin
					found_d  = 1'b1;
					hit_id_d = chain[NL].rank;
				end
			end else begin
				found_d = 1'b1;
				if (code <= wwme_pkg::LAST_LETTER) begin
					hit_mask_d = hit_mask_q | (wwme_pkg::MASK_W'(1) << code);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= wwme_pkg::ST_CLEAR;
			min_len_q    <= wwme_pkg::MIN_LEN_RESET;
			count_q      <= '0;
			for (int i = 0; i <= NL; i++) begin
				len_count_q[i] <= '0;
			end
			clr_q        <= '0;
			clr_report_q <= 1'b0;
			scan_q       <= '0;
			v_s1         <= 1'b0;
			last_s1      <= 1'b0;
			v_s2         <= 1'b0;
			last_s2      <= 1'b0;
			found_q      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			v_s1    <= issue;
			last_s1 <= issue && (scan_q == last_addr_q);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (cfg_valid && cfg_ready) begin
				min_len_q <= cfg_wdata;
			end
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (state_q == wwme_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (state_d == wwme_pkg::ST_IDLE) begin
					done_q       <= clr_report_q;
					clr_report_q <= 1'b0;
				end
			end
			if (state_q == wwme_pkg::ST_SCAN || state_q == wwme_pkg::ST_WAIT) begin
				found_q <= found_d;
				if (chain[NL].last) begin
					done_q <= 1'b1;
				end
			end
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				clr_q   <= '0;
				if (func == wwme_pkg::FUNC_CLEAR) begin
					clr_report_q <= 1'b1;
				end else if ((func == wwme_pkg::FUNC_NEXT || func == wwme_pkg::FUNC_LMASK)
					&& query_ok && count_q != '0) begin
					done_q <= 1'b0;
				end else begin
					done_q <= 1'b1;
				end
				if (word_we) begin
					count_q <= count_q + 1'b1;
					len_count_q[word_len] <= len_count_q[word_len] + 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		word_s2 <= word_rdata;
		if (state_q == wwme_pkg::ST_SCAN || state_q == wwme_pkg::ST_WAIT) begin
			hit_id_q   <= hit_id_d;
			hit_mask_q <= hit_mask_d;
			if (chain[NL].last) begin
				status_q <= found_d ? wwme_pkg::STATUS_OK : wwme_pkg::STATUS_NO_MATCH;
				rid_q    <= (found_d && func_q == wwme_pkg::FUNC_NEXT) ? hit_id_d : '0;
				lmask_q  <= (found_d && func_q == wwme_pkg::FUNC_LMASK) ? hit_mask_d : '0;
			end
		end
		if (state_q == wwme_pkg::ST_CLEAR) begin
			status_q <= wwme_pkg::STATUS_OK;
			rid_q    <= '0;
			lmask_q  <= '0;
		end
		if (accept) begin
			pat_q       <= letters;
			care_q      <= care_d;
			all_wild_q  <= (care_d == '0);
			len_q       <= word_len;
			idop_q      <= id_operand;
			pos_q       <= letter_pos;
			func_q      <= func;
			last_addr_q <= wwme_pkg::ID_W'(count_q - 1'b1);
			hit_id_q    <= '0;
			hit_mask_q  <= '0;
			status_q    <= wwme_pkg::STATUS_OK;
			rid_q       <= '0;
			lmask_q     <= '0;
			case (func)
				wwme_pkg::FUNC_INSERT: begin
					if (!len_ok || bad_letter) begin
						status_q <= wwme_pkg::STATUS_BAD;
					end else if (!word_we) begin
						status_q <= wwme_pkg::STATUS_FULL;
					end else begin
						rid_q <= len_count_q[word_len][wwme_pkg::ID_W-1:0];
					end
				end
				wwme_pkg::FUNC_EXCLUDE: rid_q <= id_operand;
				wwme_pkg::FUNC_NEXT, wwme_pkg::FUNC_LMASK: begin
					if (!query_ok) begin
						status_q <= wwme_pkg::STATUS_BAD;
					end else if (count_q == '0) begin
						status_q <= wwme_pkg::STATUS_NO_MATCH;
					end
				end
				default: status_q <= wwme_pkg::STATUS_OK;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign result_id   = rid_q;
	assign letter_mask = lmask_q;
endmodule
`default_nettype wire

@@ sv/wwme_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wwme_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [9:0]  result_id,
	input wire logic [25:0] letter_mask
);
	// A taken command either answers at once or holds the block busy.
	a_start_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("command neither answered nor in progress");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == wwme_pkg::STATUS_NO_MATCH) |-> (result_id == '0 && letter_mask == '0))
		else $error("no-match result carries data");

	a_fail_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != wwme_pkg::STATUS_OK) |-> (letter_mask == '0))
		else $error("failed command carries a letter mask");

	a_id_mask_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && letter_mask != '0) |-> (result_id == '0))
		else $error("letter mask and id given together");
endmodule

bind wildcard_word_match_engine wwme_checker u_wwme_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.result_id   (result_id),
	.letter_mask (letter_mask)
);
`default_nettype wire
